/* hw/rtl/lpt_pkg.sv */
`default_nettype none
package lpt_pkg;

    // Normalized reflectance runs from 0 to 4096, where 4096 means 1.0.
    localparam int NORM_W = 13;
    localparam logic [NORM_W-1:0] NORM_ONE = 13'd4096;

    localparam int POS_W     = 14;
    localparam int CORR_W    = 16;
    localparam int INTEG_W   = 13;
    localparam int GAIN_W    = 16;
    localparam int PITCH_W   = 12;
    localparam int LEVEL_W   = 13;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int OUT_W     = 32;

    // Locate divider: magnitude of (difference * pitch) over sum or twice the curvature.
    localparam int LOC_NUM_W = 24;
    localparam int LOC_DEN_W = 15;
    localparam int PROD_W    = 27;
    localparam int ACC_W     = 32;
    localparam int MUL_B_W   = 15;
    localparam int MUL_P_W   = 31;

    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 13'sd2560;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP,
        CFG_GAIN_INTEG,
        CFG_GAIN_DERIV,
        CFG_WARMUP,
        CFG_DETECT,
        CFG_PITCH
    } lpt_cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_WARMUP,
        STAT_LOST,
        STAT_FOUND
    } lpt_status_t;

    typedef enum logic [1:0] {
        MODE_RESTART,
        MODE_WARMUP,
        MODE_EVAL
    } lpt_mode_t;

    typedef struct packed {
        logic start;
        logic recal;
    } lpt_lane_ctl_t;

    typedef struct packed {
        logic      start;
        lpt_mode_t mode;
    } lpt_merge_cmd_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_LANES,
        TOP_MERGE,
        TOP_OUT
    } lpt_top_state_t;

    typedef enum logic [3:0] {
        MRG_IDLE,
        MRG_MUL,
        MRG_DIV_GO,
        MRG_DIV,
        MRG_POS,
        MRG_P,
        MRG_I,
        MRG_D,
        MRG_FIN,
        MRG_DONE
    } lpt_merge_state_t;

endpackage
`default_nettype wire

/* hw/rtl/lpt_div.sv */
`default_nettype none
module lpt_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 15
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output logic                  done
);

    // Restoring division, one quotient bit per cycle. The divisor must hold
    // steady while the unit is busy.
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, den});
        diff  = trial - {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

/* hw/rtl/lpt_lane.sv */
`default_nettype none
module lpt_lane #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lpt_pkg::lpt_lane_ctl_t ctl,
    input  wire logic [ADC_BITS-1:0]   sample,
    output logic [lpt_pkg::NORM_W-1:0] norm,
    output logic                       done
);

    localparam int NUM_W = ADC_BITS + 12;
    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    logic [ADC_BITS-1:0]        low_reg, low_next;
    logic [ADC_BITS-1:0]        high_reg, high_next;
    logic [ADC_BITS-1:0]        samp_reg;
    logic                       go_reg;
    logic                       done_reg;
    logic [lpt_pkg::NORM_W-1:0] norm_reg;
    logic [ADC_BITS-1:0]        delta;
    logic [ADC_BITS-1:0]        span;
    logic [NUM_W-1:0]           quo;
    logic                       div_done;

    // Calibration widens with every sample (a recalibration resets the range instead),
    // and the sample is then measured against the widened range.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (ctl.start)
        begin
            if (ctl.recal)
            begin
                low_next  = ADC_MAX;
                high_next = '0;
            end
            else
            begin
                if (sample < low_reg)
                    low_next = sample;
                if (sample > high_reg)
                    high_next = sample;
            end
        end
    end

    assign delta = samp_reg - low_reg;
    assign span  = high_reg - low_reg;

    lpt_div #(
        .NUM_W(NUM_W),
        .DEN_W(ADC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(go_reg),
        .num  ({delta, 12'b0}),
        .den  (span),
        .quo  (quo),
        .done (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= ADC_MAX;
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
            go_reg   <= ctl.start && !ctl.recal;
            done_reg <= div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            samp_reg <= sample;
        if (div_done)
        begin
            if (high_reg <= low_reg)
                norm_reg <= '0;
            else
                norm_reg <= lpt_pkg::NORM_ONE - quo[lpt_pkg::NORM_W-1:0];
        end
    end

    assign norm = norm_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

/* hw/rtl/lpt_merge.sv */
`default_nettype none
module lpt_merge (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lpt_pkg::lpt_merge_cmd_t         cmd,
    input  wire logic [lpt_pkg::NORM_W-1:0]      n_left,
    input  wire logic [lpt_pkg::NORM_W-1:0]      n_center,
    input  wire logic [lpt_pkg::NORM_W-1:0]      n_right,
    input  wire logic signed [lpt_pkg::GAIN_W-1:0] gain_prop,
    input  wire logic signed [lpt_pkg::GAIN_W-1:0] gain_integ,
    input  wire logic signed [lpt_pkg::GAIN_W-1:0] gain_deriv,
    input  wire logic [lpt_pkg::LEVEL_W-1:0]     detect_level,
    input  wire logic [lpt_pkg::PITCH_W-1:0]     sensor_pitch,
    output lpt_pkg::lpt_status_t                 status,
    output logic signed [lpt_pkg::POS_W-1:0]     position,
    output logic signed [lpt_pkg::CORR_W-1:0]    correction,
    output logic                                 done
);

    lpt_pkg::lpt_merge_state_t state_reg, state_next;
    lpt_pkg::lpt_status_t      status_reg;

    logic signed [lpt_pkg::POS_W-1:0]   pos_reg;
    logic signed [lpt_pkg::CORR_W-1:0]  corr_reg;
    logic signed [lpt_pkg::INTEG_W-1:0] integ_reg;
    logic signed [lpt_pkg::POS_W-1:0]   last_reg;
    logic signed [lpt_pkg::POS_W-1:0]   a_reg;
    logic [lpt_pkg::LOC_DEN_W-1:0]      den_reg;
    logic                               vert_reg;
    logic signed [lpt_pkg::PROD_W-1:0]  prod_reg;
    logic signed [lpt_pkg::POS_W-1:0]   e_reg;
    logic signed [lpt_pkg::INTEG_W-1:0] integ_new_reg;
    logic signed [lpt_pkg::ACC_W-1:0]   acc_reg;

    logic [lpt_pkg::NORM_W-1:0]         peak;
    logic [lpt_pkg::LOC_DEN_W-1:0]      sum;
    logic signed [lpt_pkg::LOC_DEN_W:0] curv;
    logic [lpt_pkg::LOC_DEN_W-1:0]      curv_mag2;
    logic                               lost;
    logic                               div_start;
    logic                               div_done;
    logic [lpt_pkg::LOC_NUM_W-1:0]      quo;
    logic [lpt_pkg::PROD_W-1:0]         prod_mag;
    logic [lpt_pkg::POS_W-1:0]          bound;
    logic [lpt_pkg::NORM_W-1:0]         mag;
    logic signed [lpt_pkg::POS_W-1:0]   e_val;
    logic signed [lpt_pkg::INTEG_W+1:0] integ_sum;
    logic signed [lpt_pkg::INTEG_W-1:0] integ_cl;
    logic signed [lpt_pkg::GAIN_W-1:0]  mul_a;
    logic signed [lpt_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lpt_pkg::MUL_P_W-1:0] mul_p;
    logic signed [lpt_pkg::ACC_W-1:0]   acc_base;
    logic signed [lpt_pkg::ACC_W-1:0]   acc_adj;
    logic signed [lpt_pkg::ACC_W-1:0]   acc_q;
    logic signed [lpt_pkg::CORR_W-1:0]  corr_sat;

    // Merge of the three lanes: peak, sum and curvature.
    always_comb
    begin
        peak = n_left;
        if (n_center > peak)
            peak = n_center;
        if (n_right > peak)
            peak = n_right;
        sum  = lpt_pkg::LOC_DEN_W'(n_left) + lpt_pkg::LOC_DEN_W'(n_center)
             + lpt_pkg::LOC_DEN_W'(n_right);
        curv = $signed({3'b0, n_left}) - $signed({2'b0, n_center, 1'b0})
             + $signed({3'b0, n_right});
        curv_mag2 = lpt_pkg::LOC_DEN_W'(-curv) << 1;
        lost = ({1'b0, peak} < {1'b0, detect_level});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpt_pkg::MRG_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.mode != lpt_pkg::MODE_EVAL || lost)
                        state_next = lpt_pkg::MRG_DONE;
                    else if (sum == '0)
                        state_next = lpt_pkg::MRG_P;
                    else
                        state_next = lpt_pkg::MRG_MUL;
                end
            end
            lpt_pkg::MRG_MUL:    state_next = lpt_pkg::MRG_DIV_GO;
            lpt_pkg::MRG_DIV_GO: state_next = lpt_pkg::MRG_DIV;
            lpt_pkg::MRG_DIV:
            begin
                if (div_done)
                    state_next = lpt_pkg::MRG_POS;
            end
            lpt_pkg::MRG_POS:    state_next = lpt_pkg::MRG_P;
            lpt_pkg::MRG_P:      state_next = lpt_pkg::MRG_I;
            lpt_pkg::MRG_I:      state_next = lpt_pkg::MRG_D;
            lpt_pkg::MRG_D:      state_next = lpt_pkg::MRG_FIN;
            lpt_pkg::MRG_FIN:    state_next = lpt_pkg::MRG_DONE;
            lpt_pkg::MRG_DONE:   state_next = lpt_pkg::MRG_IDLE;
            default:             state_next = lpt_pkg::MRG_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        div_start = (state_reg == lpt_pkg::MRG_DIV_GO);
        done      = (state_reg == lpt_pkg::MRG_DONE);
    end

    assign prod_mag = prod_reg[lpt_pkg::PROD_W-1] ? lpt_pkg::PROD_W'(-prod_reg)
                                                  : lpt_pkg::PROD_W'(prod_reg);

    lpt_div #(
        .NUM_W(lpt_pkg::LOC_NUM_W),
        .DEN_W(lpt_pkg::LOC_DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (prod_mag[lpt_pkg::LOC_NUM_W-1:0]),
        .den  (den_reg),
        .quo  (quo),
        .done (div_done)
    );

    // Truncated quotient gets its sign back; the vertex is clamped to
    // one and a half sensor spacings.
    always_comb
    begin
        bound = (lpt_pkg::POS_W'(sensor_pitch) + lpt_pkg::POS_W'({sensor_pitch, 1'b0})) >> 1;
        if (vert_reg && quo > lpt_pkg::LOC_NUM_W'(bound))
            mag = bound[lpt_pkg::NORM_W-1:0];
        else
            mag = quo[lpt_pkg::NORM_W-1:0];
        if (prod_reg[lpt_pkg::PROD_W-1] ^ vert_reg)
            e_val = -$signed({1'b0, mag});
        else
            e_val = $signed({1'b0, mag});
    end

    // PID arithmetic on one shared multiplier.
    always_comb
    begin
        integ_sum = $signed({{2{integ_reg[lpt_pkg::INTEG_W-1]}}, integ_reg})
                  + $signed({e_reg[lpt_pkg::POS_W-1], e_reg});
        if (integ_sum > $signed({{2{1'b0}}, lpt_pkg::INTEG_LIMIT}))
            integ_cl = lpt_pkg::INTEG_LIMIT;
        else if (integ_sum < -$signed({{2{1'b0}}, lpt_pkg::INTEG_LIMIT}))
            integ_cl = -lpt_pkg::INTEG_LIMIT;
        else
            integ_cl = integ_sum[lpt_pkg::INTEG_W-1:0];

        case (state_reg)
            lpt_pkg::MRG_P:
            begin
                mul_a = gain_prop;
                mul_b = {e_reg[lpt_pkg::POS_W-1], e_reg};
            end
            lpt_pkg::MRG_I:
            begin
                mul_a = gain_integ;
                mul_b = {{2{integ_new_reg[lpt_pkg::INTEG_W-1]}}, integ_new_reg};
            end
            default:
            begin
                mul_a = gain_deriv;
                mul_b = $signed({e_reg[lpt_pkg::POS_W-1], e_reg})
                      - $signed({last_reg[lpt_pkg::POS_W-1], last_reg});
            end
        endcase
        mul_p    = mul_a * mul_b;
        acc_base = (state_reg == lpt_pkg::MRG_P) ? '0 : acc_reg;

        acc_adj = acc_reg + (acc_reg[lpt_pkg::ACC_W-1] ? 32'sd31 : 32'sd0);
        acc_q   = acc_adj >>> 5;
        if (acc_q > 32'sd32767)
            corr_sat = 16'sh7FFF;
        else if (acc_q < -32'sd32768)
            corr_sat = 16'sh8000;
        else
            corr_sat = acc_q[lpt_pkg::CORR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lpt_pkg::MRG_IDLE;
            status_reg <= lpt_pkg::STAT_WARMUP;
            pos_reg    <= '0;
            corr_reg   <= '0;
            integ_reg  <= '0;
            last_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lpt_pkg::MRG_IDLE && cmd.start)
            begin
                case (cmd.mode)
                    lpt_pkg::MODE_RESTART:
                        status_reg <= lpt_pkg::STAT_WARMUP;
                    lpt_pkg::MODE_WARMUP:
                    begin
                        status_reg <= lpt_pkg::STAT_WARMUP;
                        corr_reg   <= '0;
                    end
                    default:
                    begin
                        if (lost)
                            status_reg <= lpt_pkg::STAT_LOST;
                    end
                endcase
            end
            if (state_reg == lpt_pkg::MRG_FIN)
            begin
                status_reg <= lpt_pkg::STAT_FOUND;
                pos_reg    <= e_reg;
                corr_reg   <= corr_sat;
                integ_reg  <= integ_new_reg;
                last_reg   <= e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lpt_pkg::MRG_IDLE)
        begin
            vert_reg <= curv[lpt_pkg::LOC_DEN_W];
            e_reg    <= '0;
            if (curv[lpt_pkg::LOC_DEN_W])
            begin
                a_reg   <= $signed({1'b0, n_left}) - $signed({1'b0, n_right});
                den_reg <= curv_mag2;
            end
            else
            begin
                a_reg   <= $signed({1'b0, n_right}) - $signed({1'b0, n_left});
                den_reg <= sum;
            end
        end
        if (state_reg == lpt_pkg::MRG_MUL)
            prod_reg <= a_reg * $signed({1'b0, sensor_pitch});
        if (state_reg == lpt_pkg::MRG_POS)
            e_reg <= e_val;
        if (state_reg == lpt_pkg::MRG_P)
            integ_new_reg <= integ_cl;
        if (state_reg == lpt_pkg::MRG_P || state_reg == lpt_pkg::MRG_I
            || state_reg == lpt_pkg::MRG_D)
            acc_reg <= acc_base + lpt_pkg::ACC_W'(mul_p);
    end

    assign status     = status_reg;
    assign position   = pos_reg;
    assign correction = corr_reg;

endmodule
`default_nettype wire

/* hw/rtl/line_position_pid_tracker_top.sv */
// Line position tracker with PID steering for a three-sensor line follower.
// Input channel (s_*): one item per sensor tick. s_tdata carries the raw left,
// center and right readings; s_tuser set to one asks for a calibration restart
// instead, and the readings are then ignored. Output channel (m_*): exactly one
// result item per input item, with the line status in m_tuser and the position
// (1/256 cm) and the Q1.15 steering correction in m_tdata.
// Configuration: a write on cfg_we sets the register named by cfg_index; it is
// meant to happen only while no item is in flight.
// Three lanes normalize the readings side by side, each on its own bit-serial
// divider of ADC_BITS + 12 steps; for a tick with a found line the merge stage
// then runs a 24-step divider for the position and three passes of one
// multiplier for the PID terms. A warm-up or line-lost tick skips the merge
// arithmetic, and a restart item skips the lanes as well. One item is in work
// at a time; the next one can be taken in the cycle after a result is loaded.
// The result waits in an output register; the next item is taken while it
// waits, but its own result is held back until the receiver drains the first.
// Reset gives a calibration range covering the whole ADC scale, a cleared
// warm-up counter, status warming up and zero position and correction.
`default_nettype none
module line_position_pid_tracker_top #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sample_left, sample_center, sample_right, zero fill
    input  wire logic [((3*ADC_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // line_position, steer_correction, zero fill
    output logic [lpt_pkg::OUT_W-1:0]           m_tdata,
    // line_status
    output logic [lpt_pkg::STATUS_W-1:0]        m_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [lpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lpt_pkg::CFG_DAT_W-1:0]  cfg_data
);

    lpt_pkg::lpt_top_state_t state_reg, state_next;

    logic signed [lpt_pkg::GAIN_W-1:0] gain_prop_reg;
    logic signed [lpt_pkg::GAIN_W-1:0] gain_integ_reg;
    logic signed [lpt_pkg::GAIN_W-1:0] gain_deriv_reg;
    logic [lpt_pkg::TICK_W-1:0]        warmup_reg;
    logic [lpt_pkg::LEVEL_W-1:0]       detect_reg;
    logic [lpt_pkg::PITCH_W-1:0]       pitch_reg;
    logic [lpt_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic                              warm_reg;
    logic                              m_tvalid_reg;
    logic [lpt_pkg::OUT_W-1:0]         m_tdata_reg;
    logic [lpt_pkg::STATUS_W-1:0]      m_tuser_reg;

    logic                              s_accept;
    logic                              out_load;
    logic                              lanes_done;
    logic [2:0]                        lane_done;
    logic [lpt_pkg::NORM_W-1:0]        norm [3];
    lpt_pkg::lpt_lane_ctl_t            lane_ctl;
    lpt_pkg::lpt_merge_cmd_t           merge_cmd;
    lpt_pkg::lpt_status_t              status;
    logic signed [lpt_pkg::POS_W-1:0]  position;
    logic signed [lpt_pkg::CORR_W-1:0] correction;
    logic                              merge_done;

    assign s_accept   = s_tvalid && s_tready;
    assign lanes_done = &lane_done;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpt_pkg::TOP_IDLE:
            begin
                if (s_tvalid)
                    state_next = s_tuser ? lpt_pkg::TOP_MERGE : lpt_pkg::TOP_LANES;
            end
            lpt_pkg::TOP_LANES:
            begin
                if (lanes_done)
                    state_next = lpt_pkg::TOP_MERGE;
            end
            lpt_pkg::TOP_MERGE:
            begin
                if (merge_done)
                    state_next = lpt_pkg::TOP_OUT;
            end
            lpt_pkg::TOP_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = lpt_pkg::TOP_IDLE;
            end
            default: state_next = lpt_pkg::TOP_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready       = (state_reg == lpt_pkg::TOP_IDLE);
        out_load       = (state_reg == lpt_pkg::TOP_OUT) && (!m_tvalid_reg || m_tready);
        lane_ctl.start = s_tvalid && (state_reg == lpt_pkg::TOP_IDLE);
        lane_ctl.recal = s_tuser;
        merge_cmd.start = (lane_ctl.start && s_tuser)
                        || ((state_reg == lpt_pkg::TOP_LANES) && lanes_done);
        if (state_reg == lpt_pkg::TOP_IDLE)
            merge_cmd.mode = lpt_pkg::MODE_RESTART;
        else if (warm_reg)
            merge_cmd.mode = lpt_pkg::MODE_WARMUP;
        else
            merge_cmd.mode = lpt_pkg::MODE_EVAL;
    end

    // The warm-up counter saturates at its top value.
    assign tick_next = (tick_reg == lpt_pkg::TICK_MAX) ? tick_reg
                                                       : tick_reg + lpt_pkg::TICK_W'(1);

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            lpt_lane #(
                .ADC_BITS(ADC_BITS)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (lane_ctl),
                .sample(s_tdata[g*ADC_BITS +: ADC_BITS]),
                .norm  (norm[g]),
                .done  (lane_done[g])
            );
        end
    endgenerate

    lpt_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (merge_cmd),
        .n_left      (norm[0]),
        .n_center    (norm[1]),
        .n_right     (norm[2]),
        .gain_prop   (gain_prop_reg),
        .gain_integ  (gain_integ_reg),
        .gain_deriv  (gain_deriv_reg),
        .detect_level(detect_reg),
        .sensor_pitch(pitch_reg),
        .status      (status),
        .position    (position),
        .correction  (correction),
        .done        (merge_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpt_pkg::TOP_IDLE;
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            warmup_reg     <= 16'd100;
            detect_reg     <= 13'd1229;
            pitch_reg      <= 12'd256;
            tick_reg       <= '0;
            warm_reg       <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lpt_pkg::CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    lpt_pkg::CFG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    lpt_pkg::CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    lpt_pkg::CFG_WARMUP:     warmup_reg     <= cfg_data;
                    lpt_pkg::CFG_DETECT:     detect_reg     <= cfg_data[lpt_pkg::LEVEL_W-1:0];
                    lpt_pkg::CFG_PITCH:      pitch_reg      <= cfg_data[lpt_pkg::PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept)
            begin
                if (s_tuser)
                    tick_reg <= '0;
                else
                begin
                    tick_reg <= tick_next;
                    warm_reg <= (tick_next < warmup_reg);
                end
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {2'b00, correction, position};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire
